[sv/adme_pkg.sv]
// Shared constants, codes and the LFO sine helper for the delay and modulation effects block.
package adme_pkg;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_CHANS = 3'd1;
    localparam logic [2:0] REG_DELAY = 3'd2;
    localparam logic [2:0] REG_DECAY = 3'd3;
    localparam logic [2:0] REG_SWEEP = 3'd4;
    localparam logic [2:0] REG_STEP  = 3'd5;

    localparam logic [1:0] MODE_ECHO  = 2'd0;
    localparam logic [1:0] MODE_MULTI = 2'd1;
    localparam logic [1:0] MODE_AM    = 2'd2;
    localparam logic [1:0] MODE_DMOD  = 2'd3;

    localparam logic [15:0] GAIN_ONE        = 16'd32768;
    localparam logic [15:0] GAIN_POINT_SEVEN = 16'd22938;
    localparam logic [15:0] DECAY_RESET     = 16'd16384;
    localparam logic [15:0] FRAMES_MAX      = 16'hFFFF;
    localparam logic [3:0]  CHANS_MAX       = 4'd8;

    localparam logic [63:0] QUARTER = 64'd1073741824;
    localparam logic [63:0] POLY_A1 = 64'd1686629713;
    localparam logic [63:0] POLY_A3 = 64'd693598669;
    localparam logic [63:0] POLY_A5 = 64'd85569306;
    localparam logic [63:0] POLY_A7 = 64'd5026995;

    // (1 + sin) / 2 in Q0.15 for a quantized phase; evaluated at elaboration only
    function automatic logic [14:0] sine_fm(input logic [31:0] f);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] mag;
        logic [63:0] fm;
        quad = f[31:30];
        r    = {34'd0, f[29:0]};
        u    = quad[0] ? (QUARTER - r) : r;
        u2   = (u * u) >> 30;
        t    = POLY_A5 - ((POLY_A7 * u2) >> 30);
        t    = POLY_A3 - ((t * u2) >> 30);
        t    = POLY_A1 - ((t * u2) >> 30);
        mag  = ((t * u) >> 30) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        fm = quad[1] ? ((64'd32768 - mag) >> 1) : ((64'd32768 + mag) >> 1);
        return fm[14:0];
    endfunction

endpackage

[sv/adme_hist_mem.sv]
// Sample history memory: one write port, one registered read port.
module adme_hist_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [15:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [15:0] o_rdata
);
    logic signed [15:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

[sv/adme_sine_rom.sv]
// LFO table: (1 + sin) / 2 per quantized phase step, registered read.
module adme_sine_rom #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_addr,
    output logic [14:0]   o_q
);
    import adme_pkg::*;

    logic [14:0] rom [DEPTH];

    function automatic logic [31:0] phase_of(input int unsigned i);
        logic [63:0] p;
        p = (64'(i) << 32) / DEPTH;
        return p[31:0];
    endfunction

    for (genvar i = 0; i < DEPTH; i++) begin : g_rom
        assign rom[i] = sine_fm(phase_of(i));
    end

    always_ff @(posedge i_clk) begin
        o_q <= rom[i_addr];
    end
endmodule

[sv/audio_delay_modulation_effects.sv]
// Top level: echo, multi-echo, tremolo and swept-delay effects over a history memory.
// A new request is accepted only while idle, so one request is processed fully before the next
// is taken. Each tap is read from the single history read port in its own read, multiply, add
// pass (ECHO_TAPS taps in multi-echo, else one).
// Reset clears counters, LFO phase and configuration registers to defaults; history memory is not cleared.
module audio_delay_modulation_effects #(
    parameter int HISTORY_DEPTH    = 262144,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ECHO_TAPS        = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import adme_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int MS = (AW < 17) ? (17 - AW) : 1;
    localparam int RW = AW + MS + 1;
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int NW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KW = $clog2(ECHO_TAPS + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_ROM  = 4'd2;
    localparam logic [3:0] S_FM   = 4'd3;
    localparam logic [3:0] S_DLY  = 4'd4;
    localparam logic [3:0] S_OFF  = 4'd5;
    localparam logic [3:0] S_MOD  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [1:0]  r_mode;
    logic [3:0]  r_chans_cfg;
    logic [12:0] r_delay;
    logic [15:0] r_decay;
    logic [12:0] r_sweep;
    logic [31:0] r_step;

    logic [3:0]  r_state;
    logic [AW-1:0] r_wp;
    logic [2:0]  r_cpos;
    logic [15:0] r_frames;
    logic [31:0] r_lfo;
    logic [14:0] r_fm;
    logic        r_ovalid;
    logic signed [15:0] r_out;

    logic signed [15:0] r_x;
    logic [IW-1:0] r_idx;
    logic [27:0] r_dprod;
    logic [15:0] r_raw;
    logic [15:0] r_tapd;
    logic [AW-1:0] r_off1;
    logic [AW-1:0] r_aoff;
    logic [15:0] r_gain;
    logic [KW-1:0] r_k;
    logic        r_en;
    logic signed [32:0] r_prod;
    logic signed [15:0] r_acc;

    logic [3:0]  chans;
    logic [KW-1:0] ntaps;
    logic [14:0] rom_q;
    logic signed [15:0] mem_q;
    logic [AW-1:0] mod_res;
    logic [AW-1:0] raddr;
    logic [AW:0] aoff_sum;
    logic [AW-1:0] aoff_next;
    logic [12:0] dly_frames;
    logic [15:0] decay_sat;
    logic signed [15:0] mul_a;
    logic [15:0] mul_g;
    logic signed [32:0] prod_adj;
    logic [31:0] gain_prod;
    logic [31+NW:0] idx_prod;
    logic        frame_end;
    logic        in_acc;
    logic        out_free;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_sample_out = r_out;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_ovalid || !i_out_stall;

    always_comb begin
        if (r_chans_cfg == 4'd0) begin
            chans = 4'd1;
        end else if (r_chans_cfg > CHANS_MAX) begin
            chans = CHANS_MAX;
        end else begin
            chans = r_chans_cfg;
        end
    end

    assign ntaps     = (r_mode == MODE_MULTI) ? KW'(ECHO_TAPS) : KW'(1);
    assign frame_end = ({1'b0, r_cpos} + 4'd1) >= chans;
    assign decay_sat = (i_cfg_data[15:0] > GAIN_ONE) ? GAIN_ONE : i_cfg_data[15:0];
    assign dly_frames = (r_mode == MODE_DMOD) ? r_dprod[27:15] : r_delay;
    assign idx_prod  = r_lfo * (NW)'(SINE_TABLE_DEPTH);

    always_comb begin
        logic [RW-1:0] rem;
        rem = RW'(r_raw);
        for (int j = MS - 1; j >= 0; j--) begin
            if (rem >= (RW'(HISTORY_DEPTH) << j)) begin
                rem = rem - (RW'(HISTORY_DEPTH) << j);
            end
        end
        mod_res = rem[AW-1:0];
    end

    assign aoff_sum  = {1'b0, r_aoff} + {1'b0, r_off1};
    assign aoff_next = (aoff_sum >= DEPTH_W) ? AW'(aoff_sum - DEPTH_W) : aoff_sum[AW-1:0];

    always_comb begin
        if (r_wp >= r_aoff) begin
            raddr = r_wp - r_aoff;
        end else begin
            raddr = AW'({1'b0, r_wp} + DEPTH_W - {1'b0, r_aoff});
        end
    end

    assign mul_a    = (r_mode == MODE_AM) ? r_x : mem_q;
    assign mul_g    = (r_mode == MODE_AM) ? {1'b0, r_fm} : r_gain;
    assign gain_prod = r_gain * r_decay;
    assign prod_adj = r_prod[32] ? (r_prod + 33'sd32767) : r_prod;

    adme_hist_mem #(
        .DEPTH(HISTORY_DEPTH),
        .AW   (AW)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (r_state == S_PREP),
        .i_waddr(r_wp),
        .i_wdata(r_x),
        .i_re   (r_state == S_RD),
        .i_raddr(raddr),
        .o_rdata(mem_q)
    );

    adme_sine_rom #(
        .DEPTH(SINE_TABLE_DEPTH),
        .IW   (IW)
    ) u_sine (
        .i_clk (i_clk),
        .i_addr(r_idx),
        .o_q   (rom_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ECHO;
            r_chans_cfg <= 4'd1;
            r_delay     <= '0;
            r_decay     <= DECAY_RESET;
            r_sweep     <= '0;
            r_step      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode      <= i_cfg_data[1:0];
                REG_CHANS: r_chans_cfg <= i_cfg_data[3:0];
                REG_DELAY: r_delay     <= i_cfg_data[12:0];
                REG_DECAY: r_decay     <= decay_sat;
                REG_SWEEP: r_sweep     <= i_cfg_data[12:0];
                REG_STEP:  r_step      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_cpos   <= '0;
            r_frames <= '0;
            r_lfo    <= '0;
            r_fm     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: r_state <= S_ROM;
                S_ROM:  r_state <= S_FM;
                S_FM: begin
                    if (r_cpos == 3'd0) begin
                        r_fm <= rom_q;
                    end
                    r_state <= S_DLY;
                end
                S_DLY: r_state <= S_OFF;
                S_OFF: r_state <= S_MOD;
                S_MOD: r_state <= S_RD;
                S_RD:  r_state <= S_MUL;
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    r_state <= (r_k == ntaps - KW'(1)) ? S_DONE : S_RD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_wp     <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        if (frame_end) begin
                            r_cpos <= '0;
                            if (r_frames != FRAMES_MAX) begin
                                r_frames <= r_frames + 16'd1;
                            end
                            r_lfo <= r_lfo + r_step;
                        end else begin
                            r_cpos <= r_cpos + 3'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample_in;
        end
        if (r_state == S_PREP) begin
            r_idx <= idx_prod[32 +: IW];
        end
        if (r_state == S_DLY) begin
            r_dprod <= r_fm * r_sweep;
        end
        if (r_state == S_OFF) begin
            r_tapd <= {3'd0, dly_frames};
            r_raw  <= dly_frames * chans;
            r_gain <= (r_mode == MODE_DMOD) ? GAIN_POINT_SEVEN : r_decay;
            r_acc  <= (r_mode == MODE_AM) ? 16'sd0 : r_x;
            r_k    <= '0;
        end
        if (r_state == S_MOD) begin
            r_off1 <= mod_res;
            r_aoff <= mod_res;
        end
        if (r_state == S_RD) begin
            unique case (r_mode)
                MODE_AM:   r_en <= 1'b1;
                MODE_DMOD: r_en <= r_frames > r_tapd;
                default:   r_en <= r_frames >= r_tapd;
            endcase
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_a * $signed({1'b0, mul_g});
            r_gain <= gain_prod[30:15];
        end
        if (r_state == S_ADD) begin
            if (r_en) begin
                r_acc <= r_acc + prod_adj[30:15];
            end
            r_k    <= r_k + KW'(1);
            r_tapd <= r_tapd + {3'd0, r_delay};
            r_aoff <= aoff_next;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_acc;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PREP))
        else $error("accepted request did not start processing");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_wp} < DEPTH_W)
        else $error("write position out of range");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ({1'b0, r_aoff} < DEPTH_W))
        else $error("tap offset out of range");

    a_tap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_k < ntaps))
        else $error("tap index overrun");

endmodule

[bench/audio_delay_modulation_effects_tb.sv]
// Self-checking testbench for the delay and modulation effects block: predictor, scoreboard, stimulus.
module audio_delay_modulation_effects_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import adme_pkg::*;

    localparam int HIST_N      = 262144;
    localparam int TAP_N       = 5;
    localparam int CYCLE_LIMIT = 3000000;

    class effect_scoreboard;
        logic [1:0]  mode;
        logic [3:0]  chans;
        logic [12:0] delay;
        logic [31:0] decay;
        logic [12:0] sweep;
        logic [31:0] step;
        logic signed [15:0] hist [HIST_N];
        int unsigned wpos;
        int unsigned cpos;
        int unsigned frames;
        logic [31:0] phase;
        int unsigned fmod;
        int unsigned gains [TAP_N];
        logic signed [15:0] pending [$];
        int errors;

        function void rebuild_gains();
            int unsigned g;
            g = decay;
            for (int k = 0; k < TAP_N; k++) begin
                gains[k] = g;
                g = (g * decay) >> 15;
            end
        endfunction

        function void reset_state();
            mode = MODE_ECHO; chans = 1; delay = 0; decay = 16384; sweep = 0; step = 0;
            wpos = 0; cpos = 0; frames = 0; phase = 0; fmod = 0; errors = 0;
            rebuild_gains();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MODE:  mode = val[1:0];
                REG_CHANS: chans = val[3:0];
                REG_DELAY: delay = val[12:0];
                REG_DECAY: begin
                    decay = {16'd0, val[15:0]};
                    if (decay > 32768) decay = 32768;
                    rebuild_gains();
                end
                REG_SWEEP: sweep = val[12:0];
                REG_STEP:  step = val;
                default: ;
            endcase
        endfunction

        function int lfo_sine(logic [31:0] ph);
            logic [63:0] r, u, u2, t, mag;
            logic [1:0]  q;
            q = ph[31:30];
            r = {34'd0, ph[29:22], 22'd0};
            u = q[0] ? (64'd1073741824 - r) : r;
            u2 = (u * u) >> 30;
            t = 64'd85569306 - ((64'd5026995 * u2) >> 30);
            t = 64'd693598669 - ((t * u2) >> 30);
            t = 64'd1686629713 - ((t * u2) >> 30);
            mag = ((t * u) >> 30) >> 15;
            if (mag > 32767) mag = 32767;
            return q[1] ? -int'(mag) : int'(mag);
        endfunction

        function int scale_q15(int x, int unsigned g);
            longint p;
            p = longint'(x) * longint'(g);
            if (p < 0) return -int'((-p) >>> 15);
            return int'(p >>> 15);
        endfunction

        function int history_at(longint unsigned off);
            int unsigned o;
            o = off % HIST_N;
            return hist[(wpos + HIST_N - o) % HIST_N];
        endfunction

        function void note_request(logic signed [15:0] x);
            int unsigned ch, d;
            int acc;
            ch = (chans == 0) ? 1 : (chans > 8) ? 8 : chans;
            if (cpos == 0) fmod = (32768 + lfo_sine(phase)) >> 1;
            hist[wpos] = x;
            acc = x;
            case (mode)
                MODE_ECHO:
                    if (frames >= delay)
                        acc += scale_q15(history_at(longint'(delay) * ch), gains[0]);
                MODE_MULTI:
                    for (int k = 1; k <= TAP_N; k++) begin
                        d = k * delay;
                        if (frames >= d) acc += scale_q15(history_at(longint'(d) * ch), gains[k-1]);
                    end
                MODE_AM: acc = scale_q15(x, fmod);
                default: begin
                    d = (fmod * sweep) >> 15;
                    if (frames > d) acc += scale_q15(history_at(longint'(d) * ch), 22938);
                end
            endcase
            wpos = (wpos + 1) % HIST_N;
            if (cpos + 1 >= ch) begin
                cpos = 0;
                if (frames < 65535) frames++;
                phase += step;
            end else begin
                cpos++;
            end
            pending.push_back(acc[15:0]);
        endfunction

        function void check_result(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample_out expected none actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: sample_out mismatch expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic signed [15:0] i_sample_in = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [15:0] o_sample_out;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_index = 0;
    logic [31:0]        i_cfg_data = 0;

    effect_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;

    audio_delay_modulation_effects u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("audio_delay_modulation_effects_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_sample_out);
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // called right after an edge; leaves the request accepted at the current edge
    task automatic send_request(logic signed [15:0] x);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(x);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(logic [1:0] m, logic [3:0] ch, logic [12:0] dl, logic [15:0] dc,
                             logic [12:0] sw, logic [31:0] st, int n, int txp, int rxp);
        drain();
        cfg_write(REG_MODE, 32'(m));
        cfg_write(REG_CHANS, 32'(ch));
        cfg_write(REG_DELAY, 32'(dl));
        cfg_write(REG_DECAY, 32'(dc));
        cfg_write(REG_SWEEP, 32'(sw));
        cfg_write(REG_STEP, st);
        tx_idle_pct = txp;
        rx_stall_pct = rxp;
        repeat (n) send_request(rand_sample());
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // wide frames first so later narrower frames never look past written history
        cfg_write(REG_CHANS, 32'd15);
        send_request(16'sh7FFF);
        send_request(-16'sh8000);
        send_request(16'sh0000);
        send_request(-16'sh0001);
        send_request(16'sh0001);
        send_request(16'sh5555);
        send_request(-16'sh5556);
        send_request(16'sh7FFF);
        run_phase(MODE_MULTI, 4'd15, 13'd3, 16'hFFFF, 13'd0, 32'd0, 250, 0, 0);
        run_phase(MODE_ECHO, 4'd8, 13'd0, 16'd0, 13'd0, 32'd0, 150, 80, 0);
        drain();
        hold_cycles = 600;
        run_phase(MODE_AM, 4'd8, 13'd0, 16'd32768, 13'd0, 32'hFFFFFFFF, 200, 0, 80);
        run_phase(MODE_DMOD, 4'd5, 13'd6143, 16'd12345, 13'h1FFF, 32'h01000000, 250, 15, 15);
        run_phase(MODE_MULTI, 4'd3, 13'h17FF, 16'd32768, 13'd0, 32'd0, 100, 0, 0);
        run_phase(MODE_ECHO, 4'd2, 13'd20, 16'd20000, 13'd0, $urandom, 250, 15, 15);
        run_phase(MODE_DMOD, 4'd0, 13'd5, 16'd1, 13'd40, 32'h02000000 | $urandom_range(65535),
                  300, 80, 0);
        run_phase(MODE_AM, 4'd1, 13'd0, 16'd0, 13'd0, 32'd12345678, 200, 0, 80);
        run_phase(MODE_MULTI, 4'd1, 13'd7, 16'd30000, 13'd0, 32'd0, 250, 15, 15);
        drain();
        if (sb.errors == 0) begin
            $display("audio_delay_modulation_effects_tb: done, clean");
        end else begin
            $display("audio_delay_modulation_effects_tb: done, errors");
        end
        $finish;
    end
endmodule
